/* design/cipid_pkg.sv */
// Shared types, codes and constants of the cascaded incremental PID motor controller.
package cipid_pkg;

    // Field and datapath widths.
    localparam int MOTOR_W  = 2;
    localparam int REF_W    = 20;
    localparam int ANGLE_W  = 32;
    localparam int SPEED_W  = 16;
    localparam int CMD_W    = 16;
    localparam int GAIN_W   = 16;
    localparam int LIM_W    = 15;
    localparam int GEAR_W   = 8;
    localparam int FRAC_W   = 10;
    localparam int SREF_W   = REF_W + GEAR_W;
    localparam int AERR_W   = 34;
    localparam int SERR_W   = 39;
    localparam int OUT_W    = 27;
    localparam int DIFF_W   = 48;
    localparam int CHUNK_W  = DIFF_W / 2;
    localparam int PROD_W   = CHUNK_W + GAIN_W + 2;
    localparam int ACC_W    = 64;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DATA_W = 16;

    // Parameter defaults.
    localparam int MOTOR_COUNT_DEF   = 4;
    localparam int CURRENT_LIMIT_DEF = 10000;
    localparam int GEAR_RATIO_DEF    = 36;

    // Register reset values.
    localparam logic [GAIN_W-1:0] ANGLE_KP_RST = 16'd5632;
    localparam logic [GAIN_W-1:0] ANGLE_KI_RST = 16'd358;
    localparam logic [GAIN_W-1:0] ANGLE_KD_RST = 16'd25600;
    localparam logic [GAIN_W-1:0] SPEED_KP_RST = 16'd2560;
    localparam logic [GAIN_W-1:0] SPEED_KI_RST = 16'd82;
    localparam logic [GAIN_W-1:0] SPEED_KD_RST = 16'd1024;
    localparam logic [LIM_W-1:0]  ANGLE_LIM_RST = 15'd15000;
    localparam logic [LIM_W-1:0]  SPEED_LIM_RST = 15'd4000;

    // Operation codes carried by each item.
    typedef enum logic [1:0] {
        OP_OFF      = 2'd0,
        OP_CURRENT  = 2'd1,
        OP_SPEED    = 2'd2,
        OP_POSITION = 2'd3
    } op_t;

    // Configuration register indexes.
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_ANGLE_KP  = 3'd0,
        CFG_ANGLE_KI  = 3'd1,
        CFG_ANGLE_KD  = 3'd2,
        CFG_SPEED_KP  = 3'd3,
        CFG_SPEED_KI  = 3'd4,
        CFG_SPEED_KD  = 3'd5,
        CFG_ANGLE_LIM = 3'd6,
        CFG_SPEED_LIM = 3'd7
    } cfg_reg_t;

    // Sequencer states.
    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SCALE,
        ST_AERR,
        ST_SERR,
        ST_DIFF,
        ST_MLO,
        ST_MHI,
        ST_AHI,
        ST_RND,
        ST_ADDO,
        ST_CLMP,
        ST_WB,
        ST_EMIT
    } seq_state_t;

    // Which loop the shared unit is working on.
    typedef enum logic {
        LOOP_ANGLE,
        LOOP_SPEED
    } loop_t;

    // Which PID term is being multiplied.
    typedef enum logic [1:0] {
        TERM_P,
        TERM_I,
        TERM_D
    } term_t;

    // Operations of the shared multiply-accumulate unit.
    typedef enum logic [2:0] {
        MAC_HOLD,
        MAC_CLEAR,
        MAC_MUL_LO,
        MAC_MUL_HI,
        MAC_ADD_HI,
        MAC_ROUND,
        MAC_ADD_OUT,
        MAC_CLAMP
    } mac_op_t;

    typedef struct packed {
        mac_op_t            op;
        logic [GAIN_W-1:0]  gain;
        logic [LIM_W-1:0]   limit;
    } mac_ctrl_t;

    // Per-motor loop state: output in Q.10, errors as integers (angle) or Q.10 (speed).
    typedef struct packed {
        logic signed [OUT_W-1:0]  out;
        logic signed [AERR_W-1:0] e1;
        logic signed [AERR_W-1:0] e2;
    } angle_state_t;

    typedef struct packed {
        logic signed [OUT_W-1:0]  out;
        logic signed [SERR_W-1:0] e1;
        logic signed [SERR_W-1:0] e2;
    } speed_state_t;

    // Item payloads.
    typedef struct packed {
        logic [MOTOR_W-1:0]         motor_index;
        op_t                        operation;
        logic signed [REF_W-1:0]    reference;
        logic signed [ANGLE_W-1:0]  angle_feedback;
        logic signed [SPEED_W-1:0]  speed_feedback;
    } in_item_t;

    typedef struct packed {
        logic [MOTOR_W-1:0]       motor_index_out;
        logic signed [CMD_W-1:0]  current_command;
    } out_item_t;

endpackage

/* design/cascaded_incremental_pid_motor_ctrl_core.sv */
// Top level of the cascaded position/speed incremental PID current controller.
//
// Use: each item on the in channel (in_valid/in_ready, in_data) names a motor,
// an operation and a reference with angle and speed feedback. One result item
// per input item leaves on the out channel (out_valid/out_ready, out_data)
// carrying the motor number and the current command. Gains and output limits
// are written through cfg_valid/cfg_ready with cfg_index and cfg_data; the
// user writes them only while the block is idle, which the block does not
// enforce. cfg_ready is always high.
// Timing: one item is worked on at a time. Position mode runs the angle loop
// and then the speed loop on the shared multiply-accumulate unit, speed mode
// the speed loop only. Each loop forms and multiplies its three gain terms,
// then rounds, adds, saturates and writes back the loop state.
// The result is registered; the next item is accepted while it still waits.
// If the receiver stalls, a finished result waits in the sequencer until the
// output register is free, and no further item is taken meanwhile.
// Reset loads the default gains and limits and clears all loop state.
module cascaded_incremental_pid_motor_ctrl_core
    import cipid_pkg::*;
#(
    parameter int MOTOR_COUNT   = MOTOR_COUNT_DEF,
    parameter int CURRENT_LIMIT = CURRENT_LIMIT_DEF,
    parameter int GEAR_RATIO    = GEAR_RATIO_DEF
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  in_item_t              in_data,
    output logic                  out_valid,
    input  logic                  out_ready,
    output out_item_t             out_data,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    localparam int MEM_DEPTH = (MOTOR_COUNT < (1 << MOTOR_W)) ? MOTOR_COUNT : (1 << MOTOR_W);
    localparam int MEM_AW    = (MEM_DEPTH > 1) ? $clog2(MEM_DEPTH) : 1;
    localparam logic [GEAR_W-1:0]      GEAR_U = GEAR_W'(GEAR_RATIO);
    localparam logic signed [REF_W-1:0] CUR_HI = REF_W'(CURRENT_LIMIT);
    localparam logic signed [REF_W-1:0] CUR_LO = -CUR_HI;
    localparam logic [MOTOR_W:0]       MOTOR_LIM =
        (MOTOR_COUNT < (1 << MOTOR_W)) ? (MOTOR_W + 1)'(MOTOR_COUNT)
                                       : (MOTOR_W + 1)'(1 << MOTOR_W);

    // Configuration registers.
    logic [GAIN_W-1:0] angle_kp_reg, angle_ki_reg, angle_kd_reg;
    logic [GAIN_W-1:0] speed_kp_reg, speed_ki_reg, speed_kd_reg;
    logic [LIM_W-1:0]  angle_lim_reg, speed_lim_reg;

    // Sequencer and datapath registers.
    seq_state_t                state_reg, state_next;
    in_item_t                  item_reg, item_next;
    logic signed [SREF_W-1:0]  scaled_reg, scaled_next;
    logic signed [DIFF_W-1:0]  err_reg, err_next;
    logic signed [DIFF_W-1:0]  diff_reg, diff_next;
    loop_t                     loop_reg, loop_next;
    term_t                     term_reg, term_next;
    logic signed [CMD_W-1:0]   cmd_reg, cmd_next;
    logic                      out_valid_reg, out_valid_next;
    out_item_t                 out_data_reg, out_data_next;

    // Combinational helpers.
    mac_ctrl_t                 mac_ctrl;
    mac_op_t                   mac_op;
    logic signed [ACC_W-1:0]   acc;
    angle_state_t              angle_rd, angle_wd;
    speed_state_t              speed_rd, speed_wd;
    logic                      angle_we, speed_we;
    logic                      motor_ok;
    logic signed [SREF_W:0]    scale_prod;
    logic signed [REF_W-1:0]   cur_clamped;
    logic signed [AERR_W-1:0]  aerr_int;
    logic signed [SREF_W:0]    serr_int;
    logic signed [DIFF_W-1:0]  aerr_q;
    logic signed [DIFF_W-1:0]  serr_spd_q;
    logic signed [DIFF_W-1:0]  serr_pos_q;
    logic signed [OUT_W-1:0]   loop_out;
    logic signed [DIFF_W-1:0]  e1_q, e2_q;
    logic signed [CMD_W-1:0]   cmd_trunc;

    // Configuration writes.
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            angle_kp_reg  <= ANGLE_KP_RST;
            angle_ki_reg  <= ANGLE_KI_RST;
            angle_kd_reg  <= ANGLE_KD_RST;
            speed_kp_reg  <= SPEED_KP_RST;
            speed_ki_reg  <= SPEED_KI_RST;
            speed_kd_reg  <= SPEED_KD_RST;
            angle_lim_reg <= ANGLE_LIM_RST;
            speed_lim_reg <= SPEED_LIM_RST;
        end
        else if (cfg_valid)
        begin
            case (cfg_reg_t'(cfg_index))
                CFG_ANGLE_KP:  angle_kp_reg  <= cfg_data;
                CFG_ANGLE_KI:  angle_ki_reg  <= cfg_data;
                CFG_ANGLE_KD:  angle_kd_reg  <= cfg_data;
                CFG_SPEED_KP:  speed_kp_reg  <= cfg_data;
                CFG_SPEED_KI:  speed_ki_reg  <= cfg_data;
                CFG_SPEED_KD:  speed_kd_reg  <= cfg_data;
                CFG_ANGLE_LIM: angle_lim_reg <= cfg_data[LIM_W-1:0];
                CFG_SPEED_LIM: speed_lim_reg <= cfg_data[LIM_W-1:0];
                default:       angle_kp_reg  <= angle_kp_reg;
            endcase
        end
    end

    // Loop state storage.
    cipid_state_mem #(
        .DEPTH (MEM_DEPTH),
        .AW    (MEM_AW)
    ) u_state_mem (
        .clk      (clk),
        .rst_n    (rst_n),
        .addr     (item_reg.motor_index[MEM_AW-1:0]),
        .angle_rd (angle_rd),
        .speed_rd (speed_rd),
        .angle_we (angle_we),
        .angle_wd (angle_wd),
        .speed_we (speed_we),
        .speed_wd (speed_wd)
    );

    // Shared arithmetic unit.
    cipid_mac u_mac (
        .clk    (clk),
        .rst_n  (rst_n),
        .ctrl   (mac_ctrl),
        .diff   (diff_reg),
        .addend (loop_out),
        .acc    (acc)
    );

    // Reference scaling, current clamp and loop errors.
    assign motor_ok   = ({1'b0, item_reg.motor_index} < MOTOR_LIM);
    assign scale_prod = item_reg.reference * $signed({1'b0, GEAR_U});

    always_comb
    begin
        if (item_reg.reference > CUR_HI)
        begin
            cur_clamped = CUR_HI;
        end
        else if (item_reg.reference < CUR_LO)
        begin
            cur_clamped = CUR_LO;
        end
        else
        begin
            cur_clamped = item_reg.reference;
        end
    end

    assign aerr_int   = AERR_W'(scaled_reg) - AERR_W'(item_reg.angle_feedback);
    assign aerr_q     = {{(DIFF_W-AERR_W-FRAC_W){aerr_int[AERR_W-1]}}, aerr_int, {FRAC_W{1'b0}}};
    assign serr_int   = (SREF_W + 1)'(scaled_reg) - (SREF_W + 1)'(item_reg.speed_feedback);
    assign serr_spd_q = {{(DIFF_W-SREF_W-1-FRAC_W){serr_int[SREF_W]}}, serr_int, {FRAC_W{1'b0}}};
    assign serr_pos_q = DIFF_W'($signed(acc[OUT_W-1:0]))
                      - DIFF_W'($signed({item_reg.speed_feedback, {FRAC_W{1'b0}}}));

    // Previous errors of the active loop, aligned to Q.10.
    always_comb
    begin
        if (loop_reg == LOOP_ANGLE)
        begin
            loop_out = angle_rd.out;
            e1_q = {{(DIFF_W-AERR_W-FRAC_W){angle_rd.e1[AERR_W-1]}}, angle_rd.e1, {FRAC_W{1'b0}}};
            e2_q = {{(DIFF_W-AERR_W-FRAC_W){angle_rd.e2[AERR_W-1]}}, angle_rd.e2, {FRAC_W{1'b0}}};
        end
        else
        begin
            loop_out = speed_rd.out;
            e1_q = {{(DIFF_W-SERR_W){speed_rd.e1[SERR_W-1]}}, speed_rd.e1};
            e2_q = {{(DIFF_W-SERR_W){speed_rd.e2[SERR_W-1]}}, speed_rd.e2};
        end
    end

    // Speed loop output truncated toward zero to an integer.
    always_comb
    begin
        if (acc[OUT_W-1] && (acc[FRAC_W-1:0] != '0))
        begin
            cmd_trunc = acc[FRAC_W+CMD_W-1:FRAC_W] + CMD_W'(1);
        end
        else
        begin
            cmd_trunc = acc[FRAC_W+CMD_W-1:FRAC_W];
        end
    end

    // Operation, gain and limit for the shared unit.
    always_comb
    begin
        mac_ctrl.op   = mac_op;
        mac_ctrl.gain = angle_kp_reg;
        case ({loop_reg, term_reg})
            {LOOP_ANGLE, TERM_P}: mac_ctrl.gain = angle_kp_reg;
            {LOOP_ANGLE, TERM_I}: mac_ctrl.gain = angle_ki_reg;
            {LOOP_ANGLE, TERM_D}: mac_ctrl.gain = angle_kd_reg;
            {LOOP_SPEED, TERM_P}: mac_ctrl.gain = speed_kp_reg;
            {LOOP_SPEED, TERM_I}: mac_ctrl.gain = speed_ki_reg;
            {LOOP_SPEED, TERM_D}: mac_ctrl.gain = speed_kd_reg;
            default:              mac_ctrl.gain = '0;
        endcase
        mac_ctrl.limit = (loop_reg == LOOP_ANGLE) ? angle_lim_reg : speed_lim_reg;
    end

    // New loop state after saturation.
    assign angle_wd = '{out: acc[OUT_W-1:0], e1: err_reg[AERR_W+FRAC_W-1:FRAC_W],
                        e2: angle_rd.e1};
    assign speed_wd = '{out: acc[OUT_W-1:0], e1: err_reg[SERR_W-1:0], e2: speed_rd.e1};

    // Sequencer: next state and outputs.
    always_comb
    begin
        state_next     = state_reg;
        item_next      = item_reg;
        scaled_next    = scaled_reg;
        err_next       = err_reg;
        diff_next      = diff_reg;
        loop_next      = loop_reg;
        term_next      = term_reg;
        cmd_next       = cmd_reg;
        out_valid_next = out_valid_reg && !out_ready;
        out_data_next  = out_data_reg;
        in_ready       = 1'b0;
        mac_op         = MAC_HOLD;
        angle_we       = 1'b0;
        speed_we       = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    item_next  = in_data;
                    state_next = ST_SCALE;
                end
            end
            ST_SCALE:
            begin
                scaled_next = scale_prod[SREF_W-1:0];
                cmd_next    = '0;
                if (!motor_ok || (item_reg.operation == OP_OFF))
                begin
                    state_next = ST_EMIT;
                end
                else if (item_reg.operation == OP_CURRENT)
                begin
                    cmd_next   = cur_clamped[CMD_W-1:0];
                    state_next = ST_EMIT;
                end
                else if (item_reg.operation == OP_SPEED)
                begin
                    state_next = ST_SERR;
                end
                else
                begin
                    state_next = ST_AERR;
                end
            end
            ST_AERR:
            begin
                err_next   = aerr_q;
                loop_next  = LOOP_ANGLE;
                term_next  = TERM_P;
                mac_op     = MAC_CLEAR;
                state_next = ST_DIFF;
            end
            ST_SERR:
            begin
                err_next   = (item_reg.operation == OP_POSITION) ? serr_pos_q : serr_spd_q;
                loop_next  = LOOP_SPEED;
                term_next  = TERM_P;
                mac_op     = MAC_CLEAR;
                state_next = ST_DIFF;
            end
            ST_DIFF:
            begin
                case (term_reg)
                    TERM_P:  diff_next = err_reg - e1_q;
                    TERM_I:  diff_next = err_reg;
                    default: diff_next = err_reg - (e1_q <<< 1) + e2_q;
                endcase
                state_next = ST_MLO;
            end
            ST_MLO:
            begin
                mac_op     = MAC_MUL_LO;
                state_next = ST_MHI;
            end
            ST_MHI:
            begin
                mac_op     = MAC_MUL_HI;
                state_next = ST_AHI;
            end
            ST_AHI:
            begin
                mac_op = MAC_ADD_HI;
                case (term_reg)
                    TERM_P:
                    begin
                        term_next  = TERM_I;
                        state_next = ST_DIFF;
                    end
                    TERM_I:
                    begin
                        term_next  = TERM_D;
                        state_next = ST_DIFF;
                    end
                    default:
                    begin
                        state_next = ST_RND;
                    end
                endcase
            end
            ST_RND:
            begin
                mac_op     = MAC_ROUND;
                state_next = ST_ADDO;
            end
            ST_ADDO:
            begin
                mac_op     = MAC_ADD_OUT;
                state_next = ST_CLMP;
            end
            ST_CLMP:
            begin
                mac_op     = MAC_CLAMP;
                state_next = ST_WB;
            end
            ST_WB:
            begin
                if (loop_reg == LOOP_ANGLE)
                begin
                    angle_we   = 1'b1;
                    state_next = ST_SERR;
                end
                else
                begin
                    speed_we   = 1'b1;
                    cmd_next   = cmd_trunc;
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    out_valid_next = 1'b1;
                    out_data_next  = '{motor_index_out: item_reg.motor_index,
                                       current_command: cmd_reg};
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            loop_reg      <= LOOP_ANGLE;
            term_reg      <= TERM_P;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            loop_reg      <= loop_next;
            term_reg      <= term_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        item_reg     <= item_next;
        scaled_reg   <= scaled_next;
        err_reg      <= err_next;
        diff_reg     <= diff_next;
        cmd_reg      <= cmd_next;
        out_data_reg <= out_data_next;
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule

/* design/cipid_mac.sv */
// Shared multiply-accumulate, rounding and saturation unit of the PID loops.
module cipid_mac
    import cipid_pkg::*;
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  mac_ctrl_t                 ctrl,
    input  logic signed [DIFF_W-1:0]  diff,
    input  logic signed [OUT_W-1:0]   addend,
    output logic signed [ACC_W-1:0]   acc
);

    localparam logic signed [ACC_W-1:0] ROUND_HALF = ACC_W'(1) <<< (FRAC_W - 1);

    logic signed [ACC_W-1:0]   acc_reg;
    logic signed [ACC_W-1:0]   acc_next;
    logic signed [PROD_W-1:0]  prod_reg;
    logic signed [PROD_W-1:0]  prod_next;
    logic signed [CHUNK_W:0]   chunk;
    logic signed [GAIN_W:0]    gain_s;
    logic signed [PROD_W-1:0]  prod_full;
    logic signed [ACC_W-1:0]   bound;

    // Pick the low (unsigned) or high (signed) half of the difference.
    always_comb
    begin
        if (ctrl.op == MAC_MUL_HI)
        begin
            chunk = {diff[DIFF_W-1], diff[DIFF_W-1:CHUNK_W]};
        end
        else
        begin
            chunk = {1'b0, diff[CHUNK_W-1:0]};
        end
    end

    assign gain_s    = {1'b0, ctrl.gain};
    assign prod_full = chunk * gain_s;
    assign bound     = {{(ACC_W-LIM_W-FRAC_W){1'b0}}, ctrl.limit, {FRAC_W{1'b0}}};

    // One operation per cycle on the accumulator.
    always_comb
    begin
        acc_next  = acc_reg;
        prod_next = prod_reg;
        case (ctrl.op)
            MAC_CLEAR:
            begin
                acc_next = '0;
            end
            MAC_MUL_LO:
            begin
                prod_next = prod_full;
            end
            MAC_MUL_HI:
            begin
                acc_next  = acc_reg + ACC_W'(prod_reg);
                prod_next = prod_full;
            end
            MAC_ADD_HI:
            begin
                acc_next = acc_reg + (ACC_W'(prod_reg) <<< CHUNK_W);
            end
            MAC_ROUND:
            begin
                acc_next = (acc_reg + ROUND_HALF) >>> FRAC_W;
            end
            MAC_ADD_OUT:
            begin
                acc_next = acc_reg + ACC_W'(addend);
            end
            MAC_CLAMP:
            begin
                if (acc_reg > bound)
                begin
                    acc_next = bound;
                end
                else if (acc_reg < -bound)
                begin
                    acc_next = -bound;
                end
            end
            default:
            begin
                acc_next = acc_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_reg <= '0;
        end
        else
        begin
            acc_reg <= acc_next;
        end
    end

    always_ff @(posedge clk)
    begin
        prod_reg <= prod_next;
    end

    assign acc = acc_reg;

endmodule

/* design/cipid_state_mem.sv */
// Per-motor state of the position and speed loops.
module cipid_state_mem
    import cipid_pkg::*;
#(
    parameter int DEPTH = MOTOR_COUNT_DEF,
    parameter int AW    = 2
)
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic [AW-1:0] addr,
    output angle_state_t  angle_rd,
    output speed_state_t  speed_rd,
    input  logic          angle_we,
    input  angle_state_t  angle_wd,
    input  logic          speed_we,
    input  speed_state_t  speed_wd
);

    angle_state_t angle_mem [DEPTH];
    speed_state_t speed_mem [DEPTH];

    // Loop state starts from zero for every motor.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < DEPTH; i++)
            begin
                angle_mem[i] <= '0;
                speed_mem[i] <= '0;
            end
        end
        else
        begin
            if (angle_we)
            begin
                angle_mem[addr] <= angle_wd;
            end
            if (speed_we)
            begin
                speed_mem[addr] <= speed_wd;
            end
        end
    end

    assign angle_rd = angle_mem[addr];
    assign speed_rd = speed_mem[addr];

endmodule

/* design/cipid_checker.sv */
// Port-level checks of the motor controller core and their binding to it.
module cipid_checker
    import cipid_pkg::*;
(
    input logic                  clk,
    input logic                  rst_n,
    input logic                  in_valid,
    input logic                  in_ready,
    input in_item_t              in_data,
    input logic                  out_valid,
    input logic                  out_ready,
    input out_item_t             out_data,
    input logic                  cfg_valid,
    input logic                  cfg_ready
);

    // A result that is not taken stays offered unchanged.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_data))
        else $error("result item changed or dropped while stalled");

    // Only one item is worked on at a time.
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("second item accepted while the first is in progress");

    // An off item with a free output gives a zero command for the same motor.
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && !out_valid && (in_data.operation == OP_OFF)
        |-> ##3 out_valid && (out_data.current_command == '0)
            && (out_data.motor_index_out == $past(in_data.motor_index, 3)))
        else $error("off item did not give a zero command");

    // Configuration writes are never held off.
    assert property (@(posedge clk) disable iff (!rst_n)
        cfg_valid |-> cfg_ready)
        else $error("configuration write stalled");

endmodule

bind cascaded_incremental_pid_motor_ctrl_core cipid_checker u_cipid_checker (.*);
